@@ rtl/bcs_pkg.sv @@
package bcs_pkg;

    localparam int DEF_MAX_BACKENDS = 8;
    localparam int DEF_COUNT_WIDTH  = 16;

    localparam int WEIGHT_SLOTS = 8;
    localparam int WEIGHT_W     = 8;
    localparam int WEIGHTS_W    = WEIGHT_SLOTS * WEIGHT_W;

    localparam int BC_W        = 4;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int ACTION_W    = 2;
    localparam int BACKEND_W   = 3;
    localparam int OUT_COUNT_W = 16;
    localparam int STATUS_W    = 2;
    // wide enough for the backend count register and the largest backend limit
    localparam int NCALC_W     = 5;

    localparam logic [BC_W-1:0]      BC_RESET      = 4'd1;
    localparam logic [WEIGHTS_W-1:0] WEIGHTS_RESET = 64'h0101_0101_0101_0101;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BACKEND_COUNT = 2'd0,
        REG_MODE          = 2'd1,
        REG_WEIGHTS       = 2'd2
    } cfg_reg_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_RR  = 2'd0,
        MODE_LC  = 2'd1,
        MODE_SED = 2'd2,
        MODE_NQ  = 2'd3
    } mode_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PICK  = 2'd0,
        ACT_OPEN  = 2'd1,
        ACT_CLOSE = 2'd2,
        ACT_QUERY = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SAT   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FETCH,
        S_LOAD,
        S_DONE
    } state_t;

endpackage

@@ rtl/backend_connection_scheduler.sv @@
// Steps: open, close and query pass through fetch, load and done to the output register; an
// index beyond the backend count goes straight to done; a pick scans the n backends in use
// (one count memory read per cycle), then drains, fetches and loads in the scanning modes,
// and goes straight to fetch in round robin. Throughput: one request at a time, taken only in idle.
// A finished response waits in its output register while the next request is taken.
// Reset: counts read as zero, cursor zero, backend count 1, round robin, all weights 1.
module backend_connection_scheduler #(
    parameter int MAX_BACKENDS = bcs_pkg::DEF_MAX_BACKENDS,
    parameter int COUNT_WIDTH  = bcs_pkg::DEF_COUNT_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bcs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  logic [bcs_pkg::ACTION_W-1:0]     action,
    input  logic [bcs_pkg::BACKEND_W-1:0]    backend,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output logic [bcs_pkg::BACKEND_W-1:0]    chosen,
    output logic [bcs_pkg::OUT_COUNT_W-1:0]  active_count,
    output logic [bcs_pkg::STATUS_W-1:0]     status
);

    localparam int IDX_W    = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;
    localparam int NCALC_W  = bcs_pkg::NCALC_W;
    localparam int BK_W     = bcs_pkg::BACKEND_W;
    localparam int OUT_W    = bcs_pkg::OUT_COUNT_W;
    localparam int WEIGHT_W = bcs_pkg::WEIGHT_W;
    localparam int MUL_W    = COUNT_WIDTH + 1;
    localparam int PROD_W   = MUL_W + WEIGHT_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    function automatic logic [WEIGHT_W-1:0] weight_at(
        input logic [bcs_pkg::WEIGHTS_W-1:0] wv,
        input logic [IDX_W-1:0]              idx
    );
        logic [WEIGHT_W-1:0] w;
        w = '0;
        for (int k = 0; k < bcs_pkg::WEIGHT_SLOTS; k++)
        begin
            if (int'(idx) == k)
            begin
                w = wv[k*WEIGHT_W +: WEIGHT_W];
            end
        end
        return w;
    endfunction

    bcs_pkg::state_t  state_reg, state_next;

    logic [bcs_pkg::BC_W-1:0]      bc_reg, bc_next;
    bcs_pkg::mode_t                mode_reg, mode_next;
    logic [bcs_pkg::WEIGHTS_W-1:0] weights_reg, weights_next;
    logic [IDX_W-1:0]              cursor_reg, cursor_next;

    bcs_pkg::action_t        act_reg, act_next;
    logic [BK_W-1:0]         tgt_reg, tgt_next;
    logic [IDX_W-1:0]        pick_reg, pick_next;
    logic [IDX_W-1:0]        scan_reg, scan_next;

    logic                    cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]        cmp_idx_reg, cmp_idx_next;
    logic                    found_reg, found_next;
    logic [IDX_W-1:0]        best_idx_reg, best_idx_next;
    logic [COUNT_WIDTH-1:0]  best_cnt_reg, best_cnt_next;
    logic [WEIGHT_W-1:0]     best_w_reg, best_w_next;
    logic                    idle_found_reg, idle_found_next;
    logic [IDX_W-1:0]        idle_idx_reg, idle_idx_next;

    logic [BK_W-1:0]         res_chosen_reg, res_chosen_next;
    logic [COUNT_WIDTH-1:0]  res_count_reg, res_count_next;
    bcs_pkg::status_t        res_status_reg, res_status_next;

    logic                    rsp_valid_reg, rsp_valid_next;
    logic [BK_W-1:0]         chosen_reg, chosen_next;
    logic [OUT_W-1:0]        acount_reg, acount_next;
    bcs_pkg::status_t        status_reg, status_next;

    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic [COUNT_WIDTH-1:0]  rd_data;
    logic                    wr_en;

    logic [NCALC_W-1:0]      n_live;
    logic                    last_issue;
    logic                    tgt_beyond;
    logic                    out_free;
    logic [IDX_W-1:0]        rr_choice;
    logic [IDX_W-1:0]        rr_after;
    logic [NCALC_W-1:0]      rr_inc;
    logic [IDX_W-1:0]        scan_choice;
    logic [IDX_W-1:0]        fetch_idx;

    logic [WEIGHT_W-1:0]     cmp_w;
    logic [MUL_W-1:0]        cnt_inc;
    logic [MUL_W-1:0]        best_inc;
    logic [PROD_W-1:0]       lhs;
    logic [PROD_W-1:0]       rhs;

    logic [COUNT_WIDTH-1:0]  load_cnt;
    bcs_pkg::status_t        load_status;
    logic                    load_write;

    bcs_count_store #(
        .DEPTH  (MAX_BACKENDS),
        .DATA_W (COUNT_WIDTH),
        .ADDR_W (IDX_W)
    ) u_count_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (pick_reg),
        .wr_data (load_cnt)
    );

    // clamp the backend count to 1..MAX_BACKENDS
    always_comb
    begin
        if (bc_reg == '0)
        begin
            n_live = NCALC_W'(1);
        end
        else if (NCALC_W'(bc_reg) > NCALC_W'(MAX_BACKENDS))
        begin
            n_live = NCALC_W'(MAX_BACKENDS);
        end
        else
        begin
            n_live = NCALC_W'(bc_reg);
        end
    end

    assign last_issue = (NCALC_W'(scan_reg) == (n_live - NCALC_W'(1)));
    assign tgt_beyond = (NCALC_W'(backend) >= n_live);
    assign out_free   = !rsp_valid_reg || rsp_ready;

    assign rr_choice = (NCALC_W'(cursor_reg) < n_live) ? cursor_reg : '0;
    assign rr_inc    = NCALC_W'(rr_choice) + NCALC_W'(1);
    assign rr_after  = (rr_inc < n_live) ? IDX_W'(rr_inc) : '0;

    always_comb
    begin
        if (mode_reg == bcs_pkg::MODE_NQ && idle_found_reg)
        begin
            scan_choice = idle_idx_reg;
        end
        else if (found_reg)
        begin
            scan_choice = best_idx_reg;
        end
        else
        begin
            scan_choice = '0;
        end
    end

    assign fetch_idx = (act_reg == bcs_pkg::ACT_PICK && mode_reg != bcs_pkg::MODE_RR)
                       ? scan_choice : pick_reg;

    // exact compare of (count+1)/weight by cross-multiplication
    assign cmp_w    = weight_at(weights_reg, cmp_idx_reg);
    assign cnt_inc  = MUL_W'(rd_data) + MUL_W'(1);
    assign best_inc = MUL_W'(best_cnt_reg) + MUL_W'(1);
    assign lhs      = PROD_W'(cnt_inc) * PROD_W'(best_w_reg);
    assign rhs      = PROD_W'(best_inc) * PROD_W'(cmp_w);

    always_comb
    begin
        load_cnt    = rd_data;
        load_status = bcs_pkg::ST_OK;
        load_write  = 1'b0;
        case (act_reg)
            bcs_pkg::ACT_OPEN:
            begin
                if (rd_data == CNT_MAX)
                begin
                    load_status = bcs_pkg::ST_SAT;
                end
                else
                begin
                    load_cnt   = rd_data + COUNT_WIDTH'(1);
                    load_write = 1'b1;
                end
            end
            bcs_pkg::ACT_CLOSE:
            begin
                if (rd_data == '0)
                begin
                    load_status = bcs_pkg::ST_SAT;
                end
                else
                begin
                    load_cnt   = rd_data - COUNT_WIDTH'(1);
                    load_write = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bcs_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    if (action == bcs_pkg::ACT_PICK)
                    begin
                        state_next = (mode_reg == bcs_pkg::MODE_RR) ? bcs_pkg::S_FETCH
                                                                    : bcs_pkg::S_SCAN;
                    end
                    else if (tgt_beyond)
                    begin
                        state_next = bcs_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = bcs_pkg::S_FETCH;
                    end
                end
            end
            bcs_pkg::S_SCAN:
            begin
                if (last_issue)
                begin
                    state_next = bcs_pkg::S_DRAIN;
                end
            end
            bcs_pkg::S_DRAIN:
            begin
                state_next = bcs_pkg::S_FETCH;
            end
            bcs_pkg::S_FETCH:
            begin
                state_next = bcs_pkg::S_LOAD;
            end
            bcs_pkg::S_LOAD:
            begin
                state_next = bcs_pkg::S_DONE;
            end
            bcs_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = bcs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bcs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = pick_reg;
        wr_en     = 1'b0;
        case (state_reg)
            bcs_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
            end
            bcs_pkg::S_SCAN:
            begin
                rd_en   = 1'b1;
                rd_addr = scan_reg;
            end
            bcs_pkg::S_FETCH:
            begin
                rd_en   = 1'b1;
                rd_addr = fetch_idx;
            end
            bcs_pkg::S_LOAD:
            begin
                wr_en = load_write;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        bc_next         = bc_reg;
        mode_next       = mode_reg;
        weights_next    = weights_reg;
        cursor_next     = cursor_reg;
        act_next        = act_reg;
        tgt_next        = tgt_reg;
        pick_next       = pick_reg;
        scan_next       = scan_reg;
        cmp_vld_next    = (state_reg == bcs_pkg::S_SCAN);
        cmp_idx_next    = scan_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_cnt_next   = best_cnt_reg;
        best_w_next     = best_w_reg;
        idle_found_next = idle_found_reg;
        idle_idx_next   = idle_idx_reg;
        res_chosen_next = res_chosen_reg;
        res_count_next  = res_count_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg;
        chosen_next     = chosen_reg;
        acount_next     = acount_reg;
        status_next     = status_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            bcs_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    act_next        = bcs_pkg::action_t'(action);
                    tgt_next        = backend;
                    scan_next       = '0;
                    found_next      = 1'b0;
                    idle_found_next = 1'b0;
                    if (action == bcs_pkg::ACT_PICK)
                    begin
                        if (mode_reg == bcs_pkg::MODE_RR)
                        begin
                            pick_next   = rr_choice;
                            cursor_next = rr_after;
                        end
                    end
                    else if (tgt_beyond)
                    begin
                        res_chosen_next = backend;
                        res_count_next  = '0;
                        res_status_next = bcs_pkg::ST_RANGE;
                    end
                    else
                    begin
                        pick_next = IDX_W'(backend);
                    end
                end
            end
            bcs_pkg::S_SCAN:
            begin
                scan_next = scan_reg + IDX_W'(1);
            end
            bcs_pkg::S_FETCH:
            begin
                pick_next = fetch_idx;
            end
            bcs_pkg::S_LOAD:
            begin
                res_chosen_next = (act_reg == bcs_pkg::ACT_PICK) ? BK_W'(pick_reg) : tgt_reg;
                res_count_next  = load_cnt;
                res_status_next = load_status;
            end
            bcs_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    chosen_next    = res_chosen_reg;
                    acount_next    = OUT_W'(res_count_reg);
                    status_next    = res_status_reg;
                end
            end
            default:
            begin
            end
        endcase

        // fold in the count that returned from the scan read
        if (cmp_vld_reg)
        begin
            if (mode_reg == bcs_pkg::MODE_LC)
            begin
                if (!found_reg || rd_data < best_cnt_reg)
                begin
                    found_next    = 1'b1;
                    best_idx_next = cmp_idx_reg;
                    best_cnt_next = rd_data;
                    best_w_next   = cmp_w;
                end
            end
            else if (cmp_w != '0)
            begin
                if (!found_reg || lhs < rhs)
                begin
                    found_next    = 1'b1;
                    best_idx_next = cmp_idx_reg;
                    best_cnt_next = rd_data;
                    best_w_next   = cmp_w;
                end
                if (mode_reg == bcs_pkg::MODE_NQ && !idle_found_reg && rd_data == '0)
                begin
                    idle_found_next = 1'b1;
                    idle_idx_next   = cmp_idx_reg;
                end
            end
        end

        if (cfg_we)
        begin
            case (cfg_index)
                bcs_pkg::REG_BACKEND_COUNT:
                begin
                    bc_next     = cfg_data[bcs_pkg::BC_W-1:0];
                    cursor_next = '0;
                end
                bcs_pkg::REG_MODE:
                begin
                    mode_next = bcs_pkg::mode_t'(cfg_data[bcs_pkg::MODE_W-1:0]);
                end
                bcs_pkg::REG_WEIGHTS:
                begin
                    weights_next = cfg_data[bcs_pkg::WEIGHTS_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bcs_pkg::S_IDLE;
            bc_reg         <= bcs_pkg::BC_RESET;
            mode_reg       <= bcs_pkg::MODE_RR;
            weights_reg    <= bcs_pkg::WEIGHTS_RESET;
            cursor_reg     <= '0;
            cmp_vld_reg    <= 1'b0;
            found_reg      <= 1'b0;
            idle_found_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bc_reg         <= bc_next;
            mode_reg       <= mode_next;
            weights_reg    <= weights_next;
            cursor_reg     <= cursor_next;
            cmp_vld_reg    <= cmp_vld_next;
            found_reg      <= found_next;
            idle_found_reg <= idle_found_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        tgt_reg        <= tgt_next;
        pick_reg       <= pick_next;
        scan_reg       <= scan_next;
        cmp_idx_reg    <= cmp_idx_next;
        best_idx_reg   <= best_idx_next;
        best_cnt_reg   <= best_cnt_next;
        best_w_reg     <= best_w_next;
        idle_idx_reg   <= idle_idx_next;
        res_chosen_reg <= res_chosen_next;
        res_count_reg  <= res_count_next;
        res_status_reg <= res_status_next;
        chosen_reg     <= chosen_next;
        acount_reg     <= acount_next;
        status_reg     <= status_next;
    end

    assign rsp_valid    = rsp_valid_reg;
    assign chosen       = chosen_reg;
    assign active_count = acount_reg;
    assign status       = status_reg;

endmodule

@@ rtl/bcs_count_store.sv @@
module bcs_count_store #(
    parameter int DEPTH  = 8,
    parameter int DATA_W = 16,
    parameter int ADDR_W = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] count_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [DEPTH-1:0]  vld_reg;
    logic              rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            count_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= count_mem[rd_addr];
        end
    end

    // an entry never written since reset reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

@@ rtl/bcs_checker.sv @@
module bcs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_ready,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input logic [bcs_pkg::BACKEND_W-1:0]   chosen,
    input logic [bcs_pkg::OUT_COUNT_W-1:0] active_count,
    input logic [bcs_pkg::STATUS_W-1:0]    status
);

    // one request in flight: the port closes right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while another is in flight");

    // an index beyond the backend count reports a zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == bcs_pkg::ST_RANGE) |-> (active_count == '0))
        else $error("out-of-range response carries a nonzero count");

    // a stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(chosen) && $stable(active_count) && $stable(status)))
        else $error("stalled response changed or dropped");

endmodule

bind backend_connection_scheduler bcs_checker u_bcs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .chosen       (chosen),
    .active_count (active_count),
    .status       (status)
);

@@ verif/testbench.sv @@
module testbench;
    import bcs_pkg::*;

    localparam int LIVE_MAX    = DEF_MAX_BACKENDS;
    localparam int BATCHES     = 10;
    localparam int BATCH_ITEMS = 185;

    typedef enum int unsigned {
        IDLE_NONE,
        IDLE_FULL,
        IDLE_SPARSE
    } idle_mix_t;

    typedef enum int unsigned {
        W_RANDOM,
        W_HOLES,
        W_TINY,
        W_ZERO,
        W_FULL
    } weight_mix_t;

    typedef struct packed {
        action_t              act;
        logic [BACKEND_W-1:0] be;
        logic [3:0]           gap;
    } conn_req_t;

    typedef struct packed {
        logic [BACKEND_W-1:0]   chosen;
        logic [OUT_COUNT_W-1:0] count;
        status_t                status;
    } sched_rsp_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    logic [ACTION_W-1:0]    action = '0;
    logic [BACKEND_W-1:0]   backend = '0;
    logic                   rsp_valid;
    logic                   rsp_ready = 1'b0;
    logic [BACKEND_W-1:0]   chosen;
    logic [OUT_COUNT_W-1:0] active_count;
    logic [STATUS_W-1:0]    status;

    // scheduler state as the testbench sees it
    logic [BC_W-1:0]        bc_q = BC_RESET;
    mode_t                  mode_q = MODE_RR;
    logic [WEIGHTS_W-1:0]   weights_q = WEIGHTS_RESET;
    logic [OUT_COUNT_W-1:0] conn_cnt [LIVE_MAX] = '{default: '0};
    int unsigned            turn_q = 0;

    conn_req_t   req_pending [$];
    sched_rsp_t  rsp_due [$];
    conn_req_t   cur_req;
    logic        have_req = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    sched_rsp_t  want_rsp;
    idle_mix_t   send_style = IDLE_SPARSE;
    idle_mix_t   rsp_style = IDLE_SPARSE;
    int          fault_cnt = 0;

    backend_connection_scheduler DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .action       (action),
        .backend      (backend),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .chosen       (chosen),
        .active_count (active_count),
        .status       (status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned live_backends();
        if (bc_q == 0)
            return 1;
        if (bc_q > LIVE_MAX)
            return LIVE_MAX;
        return bc_q;
    endfunction

    function automatic logic [WEIGHT_W-1:0] weight_at(int unsigned i);
        return weights_q[i*WEIGHT_W +: WEIGHT_W];
    endfunction

    function automatic logic [BACKEND_W-1:0] least_pick(int unsigned n);
        logic [BACKEND_W-1:0] best;
        best = '0;
        for (int i = 1; i < n; i++)
            if (conn_cnt[i] < conn_cnt[best])
                best = BACKEND_W'(i);
        return best;
    endfunction

    // compare (count+1)/weight exactly: cross-multiply, skip zero weights
    function automatic logic [BACKEND_W-1:0] delay_pick(int unsigned n);
        logic                 found;
        logic [BACKEND_W-1:0] best;
        logic [31:0]          lhs;
        logic [31:0]          rhs;
        found = 1'b0;
        best = '0;
        for (int i = 0; i < n; i++)
        begin
            if (weight_at(i) != 0)
            begin
                if (!found)
                begin
                    found = 1'b1;
                    best = BACKEND_W'(i);
                end
                else
                begin
                    lhs = (32'(conn_cnt[i]) + 32'd1) * 32'(weight_at(best));
                    rhs = (32'(conn_cnt[best]) + 32'd1) * 32'(weight_at(i));
                    if (lhs < rhs)
                        best = BACKEND_W'(i);
                end
            end
        end
        return best;
    endfunction

    function automatic logic [BACKEND_W-1:0] idle_first_pick(int unsigned n);
        for (int i = 0; i < n; i++)
            if (conn_cnt[i] == 0 && weight_at(i) != 0)
                return BACKEND_W'(i);
        return delay_pick(n);
    endfunction

    function automatic sched_rsp_t schedule_step(conn_req_t r);
        sched_rsp_t             o;
        int unsigned            n;
        logic [OUT_COUNT_W-1:0] c;
        n = live_backends();
        o.chosen = r.be;
        o.count = '0;
        o.status = ST_OK;
        if (r.act == ACT_PICK)
        begin
            case (mode_q)
                MODE_RR:
                begin
                    o.chosen = BACKEND_W'(turn_q < n ? turn_q : 0);
                    turn_q = (o.chosen + 1 < n) ? o.chosen + 1 : 0;
                end
                MODE_LC:  o.chosen = least_pick(n);
                MODE_SED: o.chosen = delay_pick(n);
                default:  o.chosen = idle_first_pick(n);
            endcase
            o.count = conn_cnt[o.chosen];
        end
        else if (r.be >= n)
        begin
            o.status = ST_RANGE;
        end
        else
        begin
            c = conn_cnt[r.be];
            case (r.act)
                ACT_OPEN:
                    if (c == '1)
                        o.status = ST_SAT;
                    else
                        c = c + 1'b1;
                ACT_CLOSE:
                    if (c == '0)
                        o.status = ST_SAT;
                    else
                        c = c - 1'b1;
                default: ;
            endcase
            conn_cnt[r.be] = c;
            o.count = c;
        end
        return o;
    endfunction

    function automatic int unsigned draw_idle(idle_mix_t style);
        case (style)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(0, 15);
            default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        endcase
    endfunction

    function automatic logic [WEIGHTS_W-1:0] draw_weights(weight_mix_t style);
        logic [WEIGHTS_W-1:0] w;
        w = {$urandom(), $urandom()};
        for (int i = 0; i < WEIGHT_SLOTS; i++)
            case (style)
                W_HOLES:
                    if ($urandom_range(0, 2) == 0)
                        w[i*WEIGHT_W +: WEIGHT_W] = '0;
                W_TINY: w[i*WEIGHT_W +: WEIGHT_W] = WEIGHT_W'($urandom_range(0, 3));
                W_ZERO: w[i*WEIGHT_W +: WEIGHT_W] = '0;
                W_FULL: w[i*WEIGHT_W +: WEIGHT_W] = '1;
                default: ;
            endcase
        return w;
    endfunction

    function automatic void push_req(action_t act, logic [BACKEND_W-1:0] be);
        conn_req_t r;
        r.act = act;
        r.be = be;
        r.gap = 4'(draw_idle(send_style));
        req_pending.push_back(r);
    endfunction

    task automatic wait_idle();
        while (req_pending.size() != 0 || have_req || rsp_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        wait_idle();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_BACKEND_COUNT:
            begin
                bc_q = data[BC_W-1:0];
                turn_q = 0;
            end
            REG_MODE: mode_q = mode_t'(data[MODE_W-1:0]);
            default:  weights_q = data;
        endcase
    endtask

    // upper bits of the narrow registers carry noise
    task automatic configure(logic [BC_W-1:0] bc, mode_t md, logic [WEIGHTS_W-1:0] wt);
        write_reg(REG_BACKEND_COUNT, ({$urandom(), $urandom()} & ~64'hF) | 64'(bc));
        write_reg(REG_MODE, ({$urandom(), $urandom()} & ~64'h3) | 64'(md));
        write_reg(REG_WEIGHTS, wt);
    endtask

    task automatic push_random(int unsigned count);
        int unsigned n;
        int unsigned roll;
        action_t     act;
        n = live_backends();
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 35)
                act = ACT_PICK;
            else if (roll < 65)
                act = ACT_OPEN;
            else if (roll < 90)
                act = ACT_CLOSE;
            else
                act = ACT_QUERY;
            // mostly address backends in use
            if ($urandom_range(0, 4) != 0)
                push_req(act, BACKEND_W'($urandom_range(0, n - 1)));
            else
                push_req(act, BACKEND_W'($urandom()));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                rsp_due.push_back(schedule_step(cur_req));
                have_req = 1'b0;
            end
            if (!have_req && req_pending.size() != 0)
            begin
                cur_req = req_pending.pop_front();
                have_req = 1'b1;
                gap_left = cur_req.gap;
            end
            if (have_req && gap_left != 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else
            begin
                req_valid <= have_req;
            end
            action <= cur_req.act;
            backend <= cur_req.be;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (rsp_due.size() == 0)
                begin
                    fault_cnt++;
                    if (fault_cnt <= 10)
                        $display("unexpected response: chosen=%0d count=%0d status=%0d",
                                 chosen, active_count, status);
                end
                else
                begin
                    want_rsp = rsp_due.pop_front();
                    if (chosen !== want_rsp.chosen || active_count !== want_rsp.count ||
                        status !== want_rsp.status)
                    begin
                        fault_cnt++;
                        if (fault_cnt <= 10)
                            $display({"response mismatch: expected chosen=%0d count=%0d ",
                                      "status=%0d, got chosen=%0d count=%0d status=%0d"},
                                     want_rsp.chosen, want_rsp.count, want_rsp.status,
                                     chosen, active_count, status);
                    end
                end
                stall_left = draw_idle(rsp_style);
            end
            if (stall_left != 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        logic [BC_W-1:0] bc;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: one backend, round robin, unit weights
        push_req(ACT_PICK, 3'd0);
        push_req(ACT_PICK, 3'd5);
        push_req(ACT_OPEN, 3'd0);
        push_req(ACT_CLOSE, 3'd0);
        push_req(ACT_CLOSE, 3'd0);
        push_req(ACT_OPEN, 3'd7);
        push_req(ACT_QUERY, 3'd0);
        push_req(ACT_QUERY, 3'd1);

        configure(4'd3, MODE_RR, WEIGHTS_RESET);
        repeat (4) push_req(ACT_PICK, 3'd0);
        // rewrite of the backend count rewinds the cursor
        write_reg(REG_BACKEND_COUNT, 64'd3);
        push_req(ACT_PICK, 3'd0);

        configure(4'd8, MODE_LC, 64'hFF00_0102_0300_0401);
        push_req(ACT_OPEN, 3'd0);
        push_req(ACT_OPEN, 3'd7);
        push_req(ACT_PICK, 3'd0);
        push_req(ACT_QUERY, 3'd7);
        write_reg(REG_MODE, 64'(MODE_SED));
        push_req(ACT_PICK, 3'd0);
        write_reg(REG_MODE, 64'(MODE_NQ));
        push_req(ACT_PICK, 3'd0);
        write_reg(REG_WEIGHTS, 64'd0);
        push_req(ACT_PICK, 3'd0);
        write_reg(REG_BACKEND_COUNT, 64'd0);
        push_req(ACT_PICK, 3'd0);
        write_reg(REG_BACKEND_COUNT, 64'd15);
        push_req(ACT_PICK, 3'd0);
        write_reg(REG_MODE, 64'(MODE_RR));
        push_req(ACT_PICK, 3'd0);
        push_req(ACT_CLOSE, 3'd0);
        push_req(ACT_CLOSE, 3'd7);

        for (int b = 0; b < BATCHES; b++)
        begin
            bc = BC_W'($urandom_range(0, 15));
            case (b)
                0: bc = 4'd8;
                1: bc = 4'd1;
                2: bc = 4'd0;
                3: bc = 4'd15;
                default: ;
            endcase
            configure(bc, mode_t'(b % 4),
                      draw_weights(weight_mix_t'(b < 5 ? b : $urandom_range(0, 4))));
            send_style = idle_mix_t'($urandom_range(0, 2));
            rsp_style = idle_mix_t'($urandom_range(0, 2));
            push_random(BATCH_ITEMS);
        end

        // load one backend, then work the scheduler around it
        configure(4'd8, MODE_LC, 64'hFF01_0203_0405_0607);
        send_style = IDLE_NONE;
        rsp_style = IDLE_NONE;
        repeat (6) push_req(ACT_OPEN, 3'd7);
        push_req(ACT_QUERY, 3'd7);
        push_req(ACT_PICK, 3'd0);
        push_req(ACT_CLOSE, 3'd7);
        push_req(ACT_OPEN, 3'd7);
        push_req(ACT_OPEN, 3'd7);

        write_reg(REG_MODE, 64'(MODE_SED));
        send_style = IDLE_FULL;
        rsp_style = IDLE_SPARSE;
        push_random(60);
        write_reg(REG_MODE, 64'(MODE_NQ));
        push_random(40);

        wait_idle();
        repeat (20) @(posedge clk);
        if (fault_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #25_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ backend_connection_scheduler.f @@
rtl/bcs_pkg.sv
rtl/bcs_count_store.sv
rtl/backend_connection_scheduler.sv
rtl/bcs_checker.sv
verif/testbench.sv
